// ----- src/rwng_pkg.sv -----
// ----------------------------------------------------------------------------
// rwng_pkg: shared types and constants for the RMS window noise gate
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rwng_pkg;

  // field and register widths
  localparam int SmpW    = 16;
  localparam int WinW    = 13;
  localparam int ThrW    = 15;
  localparam int CntW    = 8;
  localparam int LenW    = 24;
  localparam int EnergyW = 44;
  localparam int IdxW    = 3;
  localparam int CfgW    = 24;

  // shared multiplier operands
  localparam int MulAW = 30;
  localparam int MulBW = 16;
  localparam int MulPW = MulAW + MulBW;

  // parameter defaults
  localparam int DefMaxWindow    = 4096;
  localparam int DefPositionBits = 24;

  // register reset values
  localparam logic [WinW-1:0] RstWindowFrames = 13'd960;
  localparam logic [ThrW-1:0] RstOnThreshold  = 15'd197;
  localparam logic [ThrW-1:0] RstOffThreshold = 15'd131;
  localparam logic [CntW-1:0] RstAttack       = 8'd2;
  localparam logic [CntW-1:0] RstRelease      = 8'd4;
  localparam logic [LenW-1:0] RstReplLength   = 24'd0;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [IdxW-1:0] {
    REG_WINDOW_FRAMES   = 3'd0,
    REG_ON_THRESHOLD    = 3'd1,
    REG_OFF_THRESHOLD   = 3'd2,
    REG_ATTACK_WINDOWS  = 3'd3,
    REG_RELEASE_WINDOWS = 3'd4,
    REG_REPL_LENGTH     = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_L,
    ST_SQ_R,
    ST_ACC,
    ST_ON_SQ,
    ST_ON_N,
    ST_OFF_SQ,
    ST_OFF_N,
    ST_OFF_CMP,
    ST_GATE,
    ST_MOD_POS,
    ST_MOD_ADV,
    ST_EMIT
  } seq_state_e;

  function automatic logic [SmpW-1:0] abs16(input logic signed [SmpW-1:0] v);
    abs16 = v[SmpW-1] ? SmpW'(-v) : SmpW'(v);
  endfunction

endpackage

`default_nettype wire

// ----- src/rms_window_noise_gate.sv -----
// ----------------------------------------------------------------------------
// rms_window_noise_gate: RMS noise gate with hysteresis over analysis windows
// Sums squared stereo samples per window, compares against squared thresholds,
// and reports gate state, window length and looping replacement position.
// ----------------------------------------------------------------------------
// A frame is taken in the idle state, then both squares go through one shared
// registered multiplier and the sum is updated before the next frame can be
// taken. A frame that closes a window adds the threshold products and gate
// update, plus, for a non-zero replacement length, one or two passes of the
// bit-serial remainder unit over max(POSITION_BITS, 25) dividend bits each,
// plus any wait for the previous result beat to be taken. s_axis_tready is
// high only while the sequencer is idle. Configuration writes are always taken.
`default_nettype none

module rms_window_noise_gate #(
  parameter int MAX_WINDOW    = rwng_pkg::DefMaxWindow,
  parameter int POSITION_BITS = rwng_pkg::DefPositionBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input frames
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [31:0]               s_axis_tdata,  // [15:0] sample_left, [31:16] sample_right
  input  wire logic                      s_axis_tlast,  // final_frame
  // window results
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic      [39:0]               m_axis_tdata,  // [23:0] replacement_start, [36:24] window_length
  output logic                           m_axis_tuser,  // gate_open
  // configuration writes
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [rwng_pkg::IdxW-1:0] cfg_index_i,
  input  wire logic [rwng_pkg::CfgW-1:0] cfg_data_i
);
  import rwng_pkg::*;

  localparam int PosW = POSITION_BITS;
  localparam int DivW = (POSITION_BITS > LenW + 1) ? POSITION_BITS : LenW + 1;

  // configuration
  logic [WinW-1:0] win_frames_q;
  logic [ThrW-1:0] on_thr_q, off_thr_q;
  logic [CntW-1:0] attack_q, release_q;
  logic [LenW-1:0] repl_len_q;

  // sequencer and window state
  seq_state_e state_q, state_d;
  logic signed [SmpW-1:0] smp_l_q, smp_r_q;
  logic                   last_q;
  logic [EnergyW-1:0]     energy_q;
  logic [WinW-1:0]        frames_q;
  logic                   gate_q;
  logic [CntW-1:0]        loud_q, quiet_q;
  logic [PosW-1:0]        pos_q;
  logic [LenW-1:0]        start_q;
  logic                   loud_hit_q, quiet_hit_q;

  // output register
  logic            out_valid_q;
  logic            out_gate_q;
  logic [LenW-1:0] out_start_q;
  logic [WinW-1:0] out_len_q;

  // shared units
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;
  logic             mod_start;
  logic [DivW-1:0]  mod_dividend;
  logic             mod_done;
  logic [LenW-1:0]  mod_rem;

  logic            in_beat;
  logic            out_free;
  logic [WinW-1:0] win_eff;
  logic [WinW-1:0] frames_inc;
  logic            win_close;
  logic            len_zero;
  logic            gate_upd;
  logic [CntW-1:0] loud_upd, quiet_upd;

  rwng_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  rwng_mod #(
    .DW (DivW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (repl_len_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign len_zero = (repl_len_q == '0);

  // effective window size: zero acts as one, clamped to the maximum
  always_comb begin
    win_eff = win_frames_q;
    if (win_frames_q == '0) begin
      win_eff = WinW'(1);
    end else if ({19'd0, win_frames_q} > 32'(MAX_WINDOW)) begin
      win_eff = WinW'(MAX_WINDOW);
    end
  end

  assign frames_inc = frames_q + WinW'(1);
  assign win_close  = (frames_inc >= win_eff) || last_q;

  // hysteresis update
  always_comb begin
    gate_upd  = gate_q;
    loud_upd  = loud_q;
    quiet_upd = quiet_q;
    if (!gate_q) begin
      if (loud_hit_q) begin
        loud_upd = (loud_q == CntMax) ? loud_q : loud_q + CntW'(1);
      end else begin
        loud_upd = '0;
      end
      if (loud_upd >= attack_q) begin
        gate_upd  = 1'b1;
        quiet_upd = '0;
      end
    end else begin
      if (quiet_hit_q) begin
        quiet_upd = (quiet_q == CntMax) ? quiet_q : quiet_q + CntW'(1);
      end else begin
        quiet_upd = '0;
      end
      if (quiet_upd >= release_q) begin
        gate_upd = 1'b0;
        loud_upd = '0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_beat) state_d = ST_SQ_L;
      ST_SQ_L:    state_d = ST_SQ_R;
      ST_SQ_R:    state_d = ST_ACC;
      ST_ACC:     state_d = win_close ? ST_ON_SQ : ST_IDLE;
      ST_ON_SQ:   state_d = ST_ON_N;
      ST_ON_N:    state_d = ST_OFF_SQ;
      ST_OFF_SQ:  state_d = ST_OFF_N;
      ST_OFF_N:   state_d = ST_OFF_CMP;
      ST_OFF_CMP: state_d = ST_GATE;
      ST_GATE:    state_d = len_zero ? ST_EMIT : ST_MOD_POS;
      ST_MOD_POS: if (mod_done) state_d = gate_q ? ST_MOD_ADV : ST_EMIT;
      ST_MOD_ADV: if (mod_done) state_d = ST_EMIT;
      ST_EMIT:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    mod_start     = 1'b0;
    mod_dividend  = DivW'(pos_q);
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SQ_L: begin
        mul_a = MulAW'(abs16(smp_l_q));
        mul_b = abs16(smp_l_q);
      end
      ST_SQ_R: begin
        mul_a = MulAW'(abs16(smp_r_q));
        mul_b = abs16(smp_r_q);
      end
      ST_ON_SQ: begin
        mul_a = MulAW'(on_thr_q);
        mul_b = MulBW'(on_thr_q);
      end
      ST_OFF_SQ: begin
        mul_a = MulAW'(off_thr_q);
        mul_b = MulBW'(off_thr_q);
      end
      ST_ON_N, ST_OFF_N: begin
        mul_a = mul_p[MulAW-1:0];
        mul_b = MulBW'(frames_q);
      end
      ST_GATE: mod_start = !len_zero;
      ST_MOD_POS: begin
        mod_start    = mod_done && gate_q;
        mod_dividend = DivW'({1'b0, mod_rem} + (LenW+1)'(frames_q));
      end
      default: ;
    endcase
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_frames_q <= RstWindowFrames;
      on_thr_q     <= RstOnThreshold;
      off_thr_q    <= RstOffThreshold;
      attack_q     <= RstAttack;
      release_q    <= RstRelease;
      repl_len_q   <= RstReplLength;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_FRAMES:   win_frames_q <= cfg_data_i[WinW-1:0];
        REG_ON_THRESHOLD:    on_thr_q     <= cfg_data_i[ThrW-1:0];
        REG_OFF_THRESHOLD:   off_thr_q    <= cfg_data_i[ThrW-1:0];
        REG_ATTACK_WINDOWS:  attack_q     <= cfg_data_i[CntW-1:0];
        REG_RELEASE_WINDOWS: release_q    <= cfg_data_i[CntW-1:0];
        REG_REPL_LENGTH:     repl_len_q   <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // captured frame
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      smp_l_q <= s_axis_tdata[15:0];
      smp_r_q <= s_axis_tdata[31:16];
      last_q  <= s_axis_tlast;
    end
  end

  // window and gate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      energy_q    <= '0;
      frames_q    <= '0;
      gate_q      <= 1'b0;
      loud_q      <= '0;
      quiet_q     <= '0;
      pos_q       <= '0;
      start_q     <= '0;
      loud_hit_q  <= 1'b0;
      quiet_hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_SQ_R: energy_q <= energy_q + mul_p[EnergyW-1:0];
        ST_ACC: begin
          energy_q <= energy_q + mul_p[EnergyW-1:0];
          frames_q <= frames_inc;
        end
        // mean square against threshold squared: sum >= 2 * n * thr^2
        ST_OFF_SQ:  loud_hit_q  <= {3'd0, energy_q} >= {mul_p, 1'b0};
        ST_OFF_CMP: quiet_hit_q <= {3'd0, energy_q} <  {mul_p, 1'b0};
        ST_GATE: begin
          if (len_zero) begin
            gate_q  <= 1'b0;
            loud_q  <= '0;
            quiet_q <= '0;
            pos_q   <= '0;
            start_q <= '0;
          end else begin
            gate_q  <= gate_upd;
            loud_q  <= loud_upd;
            quiet_q <= quiet_upd;
          end
        end
        ST_MOD_POS: begin
          if (mod_done) begin
            start_q <= mod_rem;
            if (!gate_q) pos_q <= PosW'(mod_rem);
          end
        end
        ST_MOD_ADV: if (mod_done) pos_q <= PosW'(mod_rem);
        ST_EMIT: begin
          if (out_free) begin
            energy_q <= '0;
            frames_q <= '0;
            if (last_q) begin
              gate_q  <= 1'b0;
              loud_q  <= '0;
              quiet_q <= '0;
              pos_q   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_gate_q  <= gate_q;
      out_start_q <= start_q;
      out_len_q   <= frames_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_gate_q;
  assign m_axis_tdata  = {3'd0, out_len_q, out_start_q};

endmodule

`default_nettype wire

// ----- src/rwng_mul.sv -----
// ----------------------------------------------------------------------------
// rwng_mul: shared registered multiplier
// One unsigned product per cycle, result available the cycle after issue.
// ----------------------------------------------------------------------------
`default_nettype none

module rwng_mul (
  input  wire logic                       clk_i,
  input  wire logic [rwng_pkg::MulAW-1:0] a_i,
  input  wire logic [rwng_pkg::MulBW-1:0] b_i,
  output logic      [rwng_pkg::MulPW-1:0] p_o
);
  import rwng_pkg::*;

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- src/rwng_mod.sv -----
// ----------------------------------------------------------------------------
// rwng_mod: iterative remainder unit
// Restoring shift-subtract, one dividend bit per cycle; done pulses for one
// cycle with the remainder held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module rwng_mod #(
  parameter int DW = 25
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [DW-1:0]             dividend_i,
  input  wire logic [rwng_pkg::LenW-1:0] divisor_i,
  output logic                           done_o,
  output logic      [rwng_pkg::LenW-1:0] rem_o
);
  import rwng_pkg::*;

  localparam int StepW = $clog2(DW + 1);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [DW-1:0]    shift_q;
  logic [LenW-1:0]  rem_q;
  logic [LenW-1:0]  div_q;
  logic [LenW:0]    trial;
  logic             fits;

  assign trial = {rem_q, shift_q[DW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(DW);
    end else if (busy_q) begin
      step_q <= step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      div_q   <= divisor_i;
    end else if (busy_q) begin
      shift_q <= {shift_q[DW-2:0], 1'b0};
      rem_q   <= fits ? LenW'(trial - {1'b0, div_q}) : LenW'(trial);
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- src/rwng_checker.sv -----
// ----------------------------------------------------------------------------
// rwng_checker: port-level checks for the RMS window noise gate
// Watches the frame and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module rwng_checker #(
  parameter int MAX_WINDOW = rwng_pkg::DefMaxWindow
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one frame at a time: busy straight after a frame beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("frame taken while previous frame in work");

  // a result is only raised from the emit step, never from idle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while sequencer idle");

  // window length within 1..MAX_WINDOW
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[36:24] != 13'd0) &&
      ({19'd0, m_axis_tdata[36:24]} <= 32'(MAX_WINDOW)))
    else $error("window length out of range");

endmodule

bind rms_window_noise_gate rwng_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_rwng_checker (.*);

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RMS window noise gate
// Streams stereo frames under random back-pressure and predicts every window
// result: energy sum, loud/quiet hysteresis and the looping replacement
// position. Results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import rwng_pkg::*;

  localparam int CycleLimit = 1_000_000;

  typedef struct packed {
    logic            gate_open;
    logic [LenW-1:0] repl_start;
    logic [WinW-1:0] win_len;
  } window_result_t;

  typedef enum {LEVEL_LOUD, LEVEL_QUIET, LEVEL_NOISE} level_e;

  // predictor of window decisions plus the queue of results still owed
  class gate_scoreboard;
    logic [WinW-1:0]    win_frames;
    logic [ThrW-1:0]    on_thr;
    logic [ThrW-1:0]    off_thr;
    logic [CntW-1:0]    attack_n;
    logic [CntW-1:0]    rel_n;
    logic [LenW-1:0]    repl_len;
    logic [EnergyW-1:0] energy;
    logic [WinW-1:0]    frame_count;
    logic               gate;
    logic [CntW-1:0]    loud_run;
    logic [CntW-1:0]    quiet_run;
    logic [LenW-1:0]    play_pos;
    window_result_t     owed_windows[$];
    int                 errors;

    function new();
      win_frames  = RstWindowFrames;
      on_thr      = RstOnThreshold;
      off_thr     = RstOffThreshold;
      attack_n    = RstAttack;
      rel_n       = RstRelease;
      repl_len    = RstReplLength;
      energy      = '0;
      frame_count = '0;
      errors      = 0;
      rearm();
    endfunction

    function void rearm();
      gate      = 1'b0;
      loud_run  = '0;
      quiet_run = '0;
      play_pos  = '0;
    endfunction

    function int pending();
      return owed_windows.size();
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
      case (idx)
        REG_WINDOW_FRAMES:   win_frames = val[WinW-1:0];
        REG_ON_THRESHOLD:    on_thr     = val[ThrW-1:0];
        REG_OFF_THRESHOLD:   off_thr    = val[ThrW-1:0];
        REG_ATTACK_WINDOWS:  attack_n   = val[CntW-1:0];
        REG_RELEASE_WINDOWS: rel_n      = val[CntW-1:0];
        REG_REPL_LENGTH:     repl_len   = val[LenW-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned square(logic signed [SmpW-1:0] s);
      longint v;
      v = s;
      return v * v;
    endfunction

    task report(string msg);
      if (errors < 200) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_frame(logic [SmpW-1:0] left, logic [SmpW-1:0] right, logic last);
      int unsigned       span;
      longint unsigned   n;
      longint unsigned   on_lim;
      longint unsigned   off_lim;
      longint unsigned   start;
      window_result_t    closed_win;
      span = 32'(win_frames);
      if (span == 0) span = 1;
      if (span > DefMaxWindow) span = DefMaxWindow;
      energy = energy + EnergyW'(square(left)) + EnergyW'(square(right));
      frame_count = frame_count + 1'b1;
      if (frame_count < span && !last) return;

      n = frame_count;
      // squared thresholds scaled by 2n, so no root is taken
      on_lim  = 2 * n * on_thr * on_thr;
      off_lim = 2 * n * off_thr * off_thr;
      if (repl_len == 0) begin
        rearm();
        start = 0;
      end else begin
        if (!gate) begin
          if (energy >= on_lim) begin
            if (loud_run != CntMax) loud_run++;
          end else begin
            loud_run = '0;
          end
          if (loud_run >= attack_n) begin
            gate      = 1'b1;
            quiet_run = '0;
          end
        end else begin
          if (energy < off_lim) begin
            if (quiet_run != CntMax) quiet_run++;
          end else begin
            quiet_run = '0;
          end
          if (quiet_run >= rel_n) begin
            gate     = 1'b0;
            loud_run = '0;
          end
        end
        start = play_pos % repl_len;
        if (gate) play_pos = LenW'((start + n) % repl_len);
        else play_pos = LenW'(start);
      end
      closed_win = '{gate, LenW'(start), WinW'(n)};
      owed_windows.insert(owed_windows.size(), closed_win);
      energy      = '0;
      frame_count = '0;
      // a marked final frame ends the region: next one starts afresh
      if (last) rearm();
    endfunction

    task check_window(logic open_o, logic [LenW-1:0] start_o, logic [WinW-1:0] len_o);
      window_result_t want;
      if (owed_windows.size() == 0) begin
        report($sformatf("unexpected window: open %0d start %0d len %0d",
                         open_o, start_o, len_o));
        return;
      end
      want = owed_windows.pop_front();
      if (open_o !== want.gate_open)
        report($sformatf("gate_open %0d, want %0d", open_o, want.gate_open));
      if (start_o !== want.repl_start)
        report($sformatf("replacement_start %0d, want %0d", start_o, want.repl_start));
      if (len_o !== want.win_len)
        report($sformatf("window_length %0d, want %0d", len_o, want.win_len));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;   // [15:0] sample_left, [31:16] sample_right
  logic             s_axis_tlast = 1'b0; // final_frame
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;        // [23:0] replacement_start, [36:24] window_length
  logic             m_axis_tuser;        // gate_open
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]  cfg_data_i = '0;

  bit               calm = 1'b0;
  int               cycles = 0;
  gate_scoreboard   sb;

  rms_window_noise_gate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 21);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_window(m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[36:24]);
  end

  task automatic send_frame(input logic [15:0] left, input logic [15:0] right,
                            input logic last);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_frame(left, right, last);
    @(negedge clk_i);
  endtask

  // hold the sender until nothing is owed, then let the datapath settle
  task automatic wait_results(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_gate(input logic [CfgW-1:0] wf, input logic [CfgW-1:0] on_t,
                              input logic [CfgW-1:0] off_t, input logic [CfgW-1:0] att,
                              input logic [CfgW-1:0] rel, input logic [CfgW-1:0] len);
    wait_results(16);
    write_reg(REG_WINDOW_FRAMES, wf);
    write_reg(REG_ON_THRESHOLD, on_t);
    write_reg(REG_OFF_THRESHOLD, off_t);
    write_reg(REG_ATTACK_WINDOWS, att);
    write_reg(REG_RELEASE_WINDOWS, rel);
    write_reg(REG_REPL_LENGTH, len);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] level_sample(level_e kind, int on_t, int off_t);
    int lo;
    int mag;
    case (kind)
      LEVEL_LOUD: begin
        lo = 2 * on_t + 1;
        if (lo > 32767) lo = 32767;
        mag = $urandom_range(32767, lo);
      end
      LEVEL_QUIET: mag = $urandom_range(off_t / 2, 0);
      default: return 16'($urandom);
    endcase
    return $urandom_range(1) ? 16'(-mag) : 16'(mag);
  endfunction

  // random settings, then bursts of loud and quiet frames with some noise
  task automatic run_phase(input int ph);
    int     pick;
    int     wf;
    int     on_t;
    int     off_t;
    int     att;
    int     rel;
    int     len;
    int     seg_max;
    int     seg_left;
    level_e kind;
    pick = $urandom_range(9);
    wf = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(64, 13) :
         (pick == 2) ? 8191 : $urandom_range(12, 1);
    on_t  = $urandom_range(3000, 0);
    off_t = $urandom_range(on_t + 300, 0);
    att = ($urandom_range(9) == 0) ? $urandom_range(255, 0) : $urandom_range(4, 0);
    rel = ($urandom_range(9) == 0) ? $urandom_range(255, 0) : $urandom_range(4, 0);
    pick = $urandom_range(9);
    len = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(24'hFFFFFF, 1) :
          $urandom_range(40, 1);
    seg_max = 3 * ((wf == 0) ? 1 : (wf > 64) ? 64 : wf);
    program_gate(CfgW'(wf), CfgW'(on_t), CfgW'(off_t), CfgW'(att), CfgW'(rel),
                 CfgW'(len));
    calm = (ph == 3);
    seg_left = 0;
    kind = LEVEL_NOISE;
    for (int i = 0; i < 160; i++) begin
      if (seg_left == 0) begin
        pick = $urandom_range(99);
        kind = (pick < 45) ? LEVEL_LOUD : (pick < 85) ? LEVEL_QUIET : LEVEL_NOISE;
        seg_left = $urandom_range(seg_max, 1);
      end
      if (i == 80 && (ph == 0 || $urandom_range(2) == 0)) wait_results(0);
      send_frame(level_sample(kind, on_t, off_t), level_sample(kind, on_t, off_t),
                 $urandom_range(59) == 0);
      seg_left--;
    end
    calm = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, replacement length zero: gate held shut, window cut short
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b1);

    // zero window size acts as one; zero thresholds, attack and release
    program_gate(0, 0, 0, 0, 0, 1);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h7FFF, 16'h0001, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);

    // oversized window clamps; top thresholds and counts
    program_gate(8191, 32767, 32767, 255, 255, 24'hFFFFFF);
    repeat (4) send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b1);

    program_gate(4, 100, 50, 1, 1, 10);
    repeat (4) send_frame(16'd1000, 16'hFC18, 1'b0);
    repeat (2) send_frame(16'h0000, 16'h0000, 1'b0);
    // window shrinks under two held frames: next frame closes it
    program_gate(1, 100, 50, 1, 1, 10);
    send_frame(16'h0000, 16'h0000, 1'b0);
    // shorter replacement: position wraps on the new length
    program_gate(1, 100, 50, 1, 1, 3);
    repeat (3) send_frame(16'd1000, 16'd1000, 1'b0);

    // one long window at peak level, energy well up in the sum
    program_gate(1000, CfgW'($urandom_range(32767, 0)), CfgW'($urandom_range(32767, 0)),
                 0, 0, CfgW'($urandom_range(24'hFFFFFF, 1)));
    repeat (1000) send_frame(16'h8000, 16'h8000, 1'b0);

    for (int ph = 0; ph < 6; ph++) run_phase(ph);

    wait_results(80);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
